// File: design/hhcf_pkg.sv
// Shared types, constants and character helpers for the hex header chunk framer.
package hhcf_pkg;

  localparam logic [31:0] NodeAddressReset = 32'hC0A8_0102;
  localparam logic [7:0]  ChunkLengthReset = 8'd200;

  // Register indexes on the config port
  localparam logic RegNodeAddress = 1'b0;
  localparam logic RegChunkLength = 1'b1;

  localparam logic [7:0] ChOpen  = 8'h5B; // '['
  localparam logic [7:0] ChClose = 8'h5D; // ']'
  localparam logic [7:0] ChSep   = 8'h5F; // '_'
  localparam logic [7:0] ChKindS = 8'h53; // 'S'
  localparam logic [7:0] ChKindM = 8'h4D; // 'M'
  localparam logic [7:0] ChKindE = 8'h45; // 'E'

  localparam logic [3:0] MarkerLastIdx = 4'd14;

  // One emitted character plus its flags, from the sequencer to the top level
  typedef struct packed {
    logic [7:0] ch;
    logic       packet_end;
    logic       run_last;
    logic       done;
  } emit_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) r = 8'h30 + {4'd0, nib};
    else             r = 8'h57 + {4'd0, nib};
    return r;
  endfunction

  // Character idx of "[K_aaaaaaaa_nn]"
  function automatic logic [7:0] marker_char(input logic [7:0] kind, input logic [31:0] addr,
                                             input logic [7:0] pnum, input logic [3:0] idx);
    logic [3:0]  sel;
    logic [31:0] sh;
    logic [7:0]  r;
    sel = 4'd10 - idx;
    sh  = addr >> {sel[2:0], 2'b00};
    case (idx)
      4'd0:    r = ChOpen;
      4'd1:    r = kind;
      4'd2:    r = ChSep;
      4'd11:   r = ChSep;
      4'd12:   r = hex_char(pnum[7:4]);
      4'd13:   r = hex_char(pnum[3:0]);
      4'd14:   r = ChClose;
      default: r = hex_char(sh[3:0]);
    endcase
    return r;
  endfunction

endpackage

// File: design/hhcf_seq.sv
// Character sequencer: walks header, payload, trailer and checksum of a packet.
module hhcf_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 load_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  input  logic [31:0]          node_address_i,
  input  logic [7:0]           chunk_length_i,
  output hhcf_pkg::emit_t      emit_o
);

  typedef enum logic [3:0] {
    PH_HDR = 4'b0001,
    PH_PAY = 4'b0010,
    PH_TRL = 4'b0100,
    PH_SUM = 4'b1000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] idx_q, idx_d;
  logic [7:0] fill_q, fill_d;
  logic [7:0] pnum_q, pnum_d;
  logic [7:0] xor_q, xor_d;
  logic [8:0] new_fill;
  logic [8:0] limit;
  logic       close;

  assign new_fill = {1'b0, fill_q} + 9'd1;
  assign limit    = {(chunk_length_i == 8'd0), chunk_length_i};
  assign close    = last_i || (new_fill >= limit);

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    fill_d  = fill_q;
    pnum_d  = pnum_q;
    xor_d   = xor_q;
    emit_o  = '0;
    case (phase_q)
      PH_HDR: begin
        emit_o.ch = hhcf_pkg::marker_char((pnum_q == 8'd0) ? hhcf_pkg::ChKindS
                                                           : hhcf_pkg::ChKindM,
                                          node_address_i, pnum_q, idx_q);
        if (step_i) begin
          xor_d = xor_q ^ emit_o.ch;
          if (idx_q == hhcf_pkg::MarkerLastIdx) begin
            phase_d = PH_PAY;
            idx_d   = 4'd0;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      PH_PAY: begin
        emit_o.ch = byte_i;
        if (!close) begin
          emit_o.run_last = 1'b1;
          emit_o.done     = 1'b1;
        end
        if (step_i) begin
          xor_d = xor_q ^ byte_i;
          if (close) begin
            phase_d = PH_TRL;
            idx_d   = 4'd0;
          end else begin
            fill_d = new_fill[7:0];
          end
        end
      end
      PH_TRL: begin
        emit_o.ch = hhcf_pkg::marker_char(last_i ? hhcf_pkg::ChKindE : hhcf_pkg::ChKindM,
                                          node_address_i, pnum_q, idx_q);
        if (step_i) begin
          xor_d = xor_q ^ emit_o.ch;
          if (idx_q == hhcf_pkg::MarkerLastIdx) begin
            phase_d = PH_SUM;
            idx_d   = 4'd0;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
      end
      PH_SUM: begin
        emit_o.ch         = xor_q;
        emit_o.packet_end = 1'b1;
        emit_o.run_last   = 1'b1;
        emit_o.done       = 1'b1;
        if (step_i) begin
          xor_d  = 8'd0;
          fill_d = 8'd0;
          pnum_d = last_i ? 8'd0 : pnum_q + 8'd1;
        end
      end
      default: begin
        phase_d = PH_HDR;
        idx_d   = 4'd0;
      end
    endcase
    // a fresh item opens with a header only when no packet is open
    if (load_i) begin
      phase_d = (fill_d == 8'd0) ? PH_HDR : PH_PAY;
      idx_d   = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      idx_q   <= 4'd0;
      fill_q  <= 8'd0;
      pnum_q  <= 8'd0;
      xor_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      fill_q  <= fill_d;
      pnum_q  <= pnum_d;
      xor_q   <= xor_d;
    end
  end

endmodule

// File: design/hex_header_chunk_framer_top.sv
// Top level of the hex header chunk framer: input and output registers, config port.
//
// Each accepted message byte produces one output character per unstalled cycle: one
// for a byte in the middle of a packet, 16 for the byte that opens a packet (header
// plus byte), 17 for the one that closes it (byte, trailer, checksum) and 32 for a
// one-byte packet. The next input item is taken in the cycle the current item emits
// its final character, so with a free output side the input runs at one item per
// cycle inside a packet; the single character sequencer sets the rate.
module hex_header_chunk_framer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  logic        s_axis_tlast,   // msg_last
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_char
  output logic        m_axis_tuser,   // [0] packet_end
  output logic        m_axis_tlast,   // run_last
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] node_address_q, node_address_d;
  logic [7:0]  chunk_length_q, chunk_length_d;
  logic        cfg_wr;

  logic        in_v_q, in_v_d;
  logic [7:0]  in_byte_q, in_byte_d;
  logic        in_last_q, in_last_d;

  logic        out_v_q, out_v_d;
  logic [7:0]  out_char_q, out_char_d;
  logic        out_end_q, out_end_d;
  logic        out_last_q, out_last_d;

  logic            step;
  logic            load;
  hhcf_pkg::emit_t emit;

  // config registers, word address in paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    node_address_d = node_address_q;
    chunk_length_d = chunk_length_q;
    if (cfg_wr) begin
      case (paddr[2])
        hhcf_pkg::RegNodeAddress: node_address_d = pwdata;
        hhcf_pkg::RegChunkLength: chunk_length_d = pwdata[7:0];
        default: ;
      endcase
    end
    case (paddr[2])
      hhcf_pkg::RegNodeAddress: prdata = node_address_q;
      hhcf_pkg::RegChunkLength: prdata = {24'd0, chunk_length_q};
      default:                  prdata = 32'd0;
    endcase
  end

  // handshake
  assign step          = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || (step && emit.done);
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_v_d    = in_v_q;
    in_byte_d = in_byte_q;
    in_last_d = in_last_q;
    if (load) begin
      in_v_d    = 1'b1;
      in_byte_d = s_axis_tdata;
      in_last_d = s_axis_tlast;
    end else if (step && emit.done) begin
      in_v_d = 1'b0;
    end

    out_v_d    = out_v_q && !m_axis_tready;
    out_char_d = out_char_q;
    out_end_d  = out_end_q;
    out_last_d = out_last_q;
    if (step) begin
      out_v_d    = 1'b1;
      out_char_d = emit.ch;
      out_end_d  = emit.packet_end;
      out_last_d = emit.run_last;
    end
  end

  hhcf_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .load_i         (load),
    .byte_i         (in_byte_q),
    .last_i         (in_last_q),
    .node_address_i (node_address_q),
    .chunk_length_i (chunk_length_q),
    .emit_o         (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_address_q <= hhcf_pkg::NodeAddressReset;
      chunk_length_q <= hhcf_pkg::ChunkLengthReset;
      in_v_q         <= 1'b0;
      out_v_q        <= 1'b0;
    end else begin
      node_address_q <= node_address_d;
      chunk_length_q <= chunk_length_d;
      in_v_q         <= in_v_d;
      out_v_q        <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q  <= in_byte_d;
    in_last_q  <= in_last_d;
    out_char_q <= out_char_d;
    out_end_q  <= out_end_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tuser  = out_end_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: tb/sv/tb.sv
// Testbench for the hex header chunk framer: directed table, then random messages.
module tb;

  localparam int ClkHalf    = 10;
  localparam int QuietLimit = 2000;
  localparam int TailCycles = 20;

  localparam logic [127:0] HexDigits = "0123456789abcdef";

  typedef struct packed {
    logic [7:0] ch;
    logic       packet_end;
    logic       run_last;
  } frame_char_t;

  typedef struct packed {
    logic        is_cfg;
    logic        reg_idx;
    logic [31:0] value;
    logic        last;
    logic [5:0]  n_chars;   // 0: leave it to the framing model
  } stim_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = 3'd0;
  logic [31:0] pwdata        = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  hex_header_chunk_framer_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b1;
    #(ClkHalf);
    clk_i = 1'b0;
    #(ClkHalf);
  end

  // framing model state
  frame_char_t framed_q[$];
  int          run_len_q[$];
  logic [31:0] mdl_addr;
  logic [7:0]  mdl_len;
  logic [7:0]  mdl_fill;
  logic [7:0]  mdl_pnum;
  logic [7:0]  mdl_xsum;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int fails         = 0;
  int quiet_cycles  = 0;
  int seen_len      = 0;
  int want_len;
  frame_char_t want;

  function automatic logic [7:0] ascii_hex(logic [3:0] nib);
    return HexDigits[(15 - nib) * 8 +: 8];
  endfunction

  function automatic void push_char(logic [7:0] c, logic pend);
    frame_char_t fc;
    fc.ch         = c;
    fc.packet_end = pend;
    fc.run_last   = 1'b0;
    framed_q.push_back(fc);
    if (!pend) mdl_xsum = mdl_xsum ^ c;
  endfunction

  function automatic void push_marker(logic [7:0] kind);
    push_char(hhcf_pkg::ChOpen, 1'b0);
    push_char(kind, 1'b0);
    push_char(hhcf_pkg::ChSep, 1'b0);
    for (int k = 7; k >= 0; k--) push_char(ascii_hex(mdl_addr[4*k +: 4]), 1'b0);
    push_char(hhcf_pkg::ChSep, 1'b0);
    push_char(ascii_hex(mdl_pnum[7:4]), 1'b0);
    push_char(ascii_hex(mdl_pnum[3:0]), 1'b0);
    push_char(hhcf_pkg::ChClose, 1'b0);
  endfunction

  // expected characters for one accepted message byte
  function automatic void frame_byte(logic [7:0] b, logic last);
    int limit;
    int nfill;
    limit = (mdl_len == 8'd0) ? 256 : int'(mdl_len);
    if (mdl_fill == 8'd0) begin
      mdl_xsum = 8'd0;
      push_marker((mdl_pnum == 8'd0) ? hhcf_pkg::ChKindS : hhcf_pkg::ChKindM);
    end
    push_char(b, 1'b0);
    nfill = int'(mdl_fill) + 1;
    if (last || nfill >= limit) begin
      push_marker(last ? hhcf_pkg::ChKindE : hhcf_pkg::ChKindM);
      push_char(mdl_xsum, 1'b1);
      mdl_xsum = 8'd0;
      mdl_fill = 8'd0;
      mdl_pnum = last ? 8'd0 : mdl_pnum + 8'd1;
    end else begin
      mdl_fill = nfill[7:0];
    end
    framed_q[framed_q.size() - 1].run_last = 1'b1;
  endfunction

  function automatic stim_row_t item_row(logic [7:0] b, logic last, int n);
    stim_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = hhcf_pkg::RegNodeAddress;
    r.value   = {24'd0, b};
    r.last    = last;
    r.n_chars = n[5:0];
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic idx, logic [31:0] v);
    stim_row_t r;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.value   = v;
    r.last    = 1'b0;
    r.n_chars = 6'd0;
    return r;
  endfunction

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_len = seen_len + 1;
      if (framed_q.size() == 0) begin
        $display("%0t: unexpected item: expected none, got ch=%h end=%b last=%b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        fails++;
      end else begin
        want = framed_q.pop_front();
        if (m_axis_tdata !== want.ch || m_axis_tuser !== want.packet_end ||
            m_axis_tlast !== want.run_last) begin
          $display("%0t: mismatch: expected ch=%h end=%b last=%b, got ch=%h end=%b last=%b",
                   $time, want.ch, want.packet_end, want.run_last,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fails++;
        end
      end
      if (m_axis_tlast) begin
        if (run_len_q.size() != 0) begin
          want_len = run_len_q.pop_front();
          if (want_len != 0 && want_len != seen_len) begin
            $display("%0t: run length mismatch: expected %0d, got %0d",
                     $time, want_len, seen_len);
            fails++;
          end
        end
        seen_len = 0;
      end
    end
  end

  // no handshake of any kind for too long means a hang
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("[hex_header_chunk_framer_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    frame_byte(b, last);
  endtask

  // drop valid and let every expected character come out
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    logic [31:0] rb_want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == hhcf_pkg::RegNodeAddress) mdl_addr = v;
    else                                 mdl_len  = v[7:0];
    // read it back
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rb_want = (idx == hhcf_pkg::RegNodeAddress) ? mdl_addr : {24'd0, mdl_len};
    if (prdata !== rb_want) begin
      $display("%0t: register %0d readback: expected %h, got %h", $time, idx, rb_want, prdata);
      fails++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random messages; the phase may stop inside a message
  task automatic random_phase(int send_pct, int stall_v, logic [7:0] len, int n_items,
                              int max_msg);
    int sent;
    int msg_len;
    drain();
    send_idle_pct = send_pct;
    stall_pct     = stall_v;
    write_reg(hhcf_pkg::RegNodeAddress, $urandom());
    write_reg(hhcf_pkg::RegChunkLength, {24'd0, len});
    sent = 0;
    while (sent < n_items) begin
      msg_len = $urandom_range(1, max_msg);
      for (int k = 0; k < msg_len && sent < n_items; k++) begin
        send_byte($urandom_range(255), k == msg_len - 1);
        sent++;
      end
      if ($urandom_range(19) == 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        while (framed_q.size() != 0) @(posedge clk_i);
      end
    end
  endtask

  stim_row_t dir_rows[$];

  initial begin
    mdl_addr = hhcf_pkg::NodeAddressReset;
    mdl_len  = hhcf_pkg::ChunkLengthReset;
    mdl_fill = 8'd0;
    mdl_pnum = 8'd0;
    mdl_xsum = 8'd0;

    // one-byte message, then a short one at reset settings
    dir_rows.push_back(item_row(8'h00, 1'b1, 32));
    dir_rows.push_back(item_row(8'hFF, 1'b0, 16));
    dir_rows.push_back(item_row(8'h5A, 1'b0, 1));
    dir_rows.push_back(item_row(8'hA5, 1'b1, 17));
    // one byte per packet: S, M and E markers, then packets of three bytes
    dir_rows.push_back(cfg_row(hhcf_pkg::RegNodeAddress, 32'h0000_0000));
    dir_rows.push_back(cfg_row(hhcf_pkg::RegChunkLength, 32'd1));
    dir_rows.push_back(item_row(8'h12, 1'b0, 32));
    dir_rows.push_back(item_row(8'h34, 1'b0, 32));
    dir_rows.push_back(item_row(8'h56, 1'b1, 32));
    dir_rows.push_back(cfg_row(hhcf_pkg::RegNodeAddress, 32'hFFFF_FFFF));
    dir_rows.push_back(cfg_row(hhcf_pkg::RegChunkLength, 32'd3));
    dir_rows.push_back(item_row(8'h01, 1'b0, 16));
    dir_rows.push_back(item_row(8'h02, 1'b0, 1));
    dir_rows.push_back(item_row(8'h03, 1'b0, 17));
    dir_rows.push_back(item_row(8'h04, 1'b0, 16));
    // length dropped to the fill of the open packet
    dir_rows.push_back(cfg_row(hhcf_pkg::RegChunkLength, 32'd1));
    dir_rows.push_back(item_row(8'h05, 1'b0, 17));
    dir_rows.push_back(item_row(8'h06, 1'b0, 32));
    dir_rows.push_back(cfg_row(hhcf_pkg::RegChunkLength, 32'd255));
    dir_rows.push_back(item_row(8'h07, 1'b0, 16));
    // new address while the packet is open goes into its trailer
    dir_rows.push_back(cfg_row(hhcf_pkg::RegNodeAddress, 32'h89AB_CDEF));
    dir_rows.push_back(item_row(8'h08, 1'b1, 17));
    // zero length means 256
    dir_rows.push_back(cfg_row(hhcf_pkg::RegChunkLength, 32'd0));
    dir_rows.push_back(item_row(8'h80, 1'b0, 16));
    dir_rows.push_back(item_row(8'h7F, 1'b1, 17));

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        run_len_q.push_back(int'(dir_rows[i].n_chars));
        send_byte(dir_rows[i].value[7:0], dir_rows[i].last);
      end
    end

    random_phase(0, 0, 8'd3, 25, 12);
    random_phase(47, 0, 8'd1, 25, 6);
    random_phase(0, 47, 8'd7, 25, 20);
    random_phase(32, 32, 8'd255, 25, 30);
    random_phase(32, 32, 8'(($urandom_range(2, 254))), 13, 16);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fails == 0 && framed_q.size() == 0) begin
      $display("[hex_header_chunk_framer_top] OK");
    end else begin
      $display("[hex_header_chunk_framer_top] ERROR");
    end
    $finish;
  end

endmodule
